>>> rtl/shm_pkg.sv
// ----------------------------------------------------------------------------
// shm_pkg: shared types and constants of the sensor health monitor
// Status codes, register map, configuration, state and result structs.
// ----------------------------------------------------------------------------
`default_nettype none

package shm_pkg;

  // Widest sample in bytes
  localparam int unsigned MAX_BYTES = 4;

  localparam int unsigned DataW  = 32;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned BpsW   = 3;
  localparam int unsigned RetryW = 8;
  localparam int unsigned CountW = 16;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NAK     = 3'd1,
    ST_BUS_ERR = 3'd2,
    ST_NO_DATA = 3'd3,
    ST_UNKNOWN = 3'd4
  } bus_status_e;

  // Register word index (paddr[4:2])
  typedef enum logic [2:0] {
    REG_BYTES_PER_SAMPLE  = 3'd0,
    REG_NAK_RETRY_LIMIT   = 3'd1,
    REG_RANGE_LOW         = 3'd2,
    REG_RANGE_HIGH        = 3'd3,
    REG_STUCK_THRESHOLD   = 3'd4,
    REG_DROPOUT_THRESHOLD = 3'd5
  } reg_index_e;

  typedef struct packed {
    logic [BpsW-1:0]         bytes_per_sample;
    logic [RetryW-1:0]       nak_retry_limit;
    logic signed [DataW-1:0] range_low;
    logic signed [DataW-1:0] range_high;
    logic [CountW-1:0]       stuck_threshold;
    logic [CountW-1:0]       dropout_threshold;
  } shm_cfg_t;

  typedef struct packed {
    logic bus_error;
    logic nak;
    logic dropout;
    logic range;
    logic stuck;
  } shm_faults_t;

  typedef struct packed {
    shm_faults_t             faults;
    logic signed [DataW-1:0] last_accepted;
    logic                    have_accepted;
    logic [CountW-1:0]       nodata_count;
    logic [CountW-1:0]       repeat_count;
    logic [RetryW-1:0]       attempt_count;
  } shm_state_t;

  typedef struct packed {
    logic retry_request;
    logic publish;
  } shm_result_t;

endpackage

`default_nettype wire

>>> rtl/sensor_health_monitor.sv
// ----------------------------------------------------------------------------
// sensor_health_monitor: bus read health tracker for one sensor
// Input word register, combinational evaluation, state and result registers.
// ----------------------------------------------------------------------------
// Each accepted word is one bus read attempt (status plus right-aligned raw
// bytes) and yields exactly one result word. The block sustains one word per
// cycle while out_stall_i is low: a word lands in the input register, is
// evaluated in one pass against the health state and moves into the result
// register when that register is empty or being taken. The input register
// keeps taking one more word while a result is stalled, so the input side
// only stalls when both registers are full. The fault flags, good_value_o
// and value_valid_o shown with a result are the monitor state after that
// word; retry_request_o asks the bus side for another attempt, publish_o
// marks a newly accepted in-range sample. Write configuration only while
// no word is in flight; reads of the registers return their values.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_health_monitor (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // configuration port
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [shm_pkg::AddrW-1:0] paddr,
  input  wire logic [shm_pkg::DataW-1:0] pwdata,
  output logic      [shm_pkg::DataW-1:0] prdata,
  output logic                           pready,
  // attempt words
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [2:0]                bus_status_i,
  input  wire logic [shm_pkg::DataW-1:0] raw_bytes_i,
  // result words
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic                           retry_request_o,
  output logic                           healthy_o,
  output logic                           fault_bus_error_o,
  output logic                           fault_nak_o,
  output logic                           fault_dropout_o,
  output logic                           fault_range_o,
  output logic                           fault_stuck_o,
  output logic signed [shm_pkg::DataW-1:0] good_value_o,
  output logic                           value_valid_o,
  output logic                           publish_o
);
  import shm_pkg::*;

  shm_cfg_t    cfg;
  shm_state_t  state_q, state_d;
  shm_result_t result_d, result_q;

  logic             in_valid_q, in_valid_d;
  logic [2:0]       bus_status_q;
  logic [DataW-1:0] raw_bytes_q;
  logic             out_valid_q, out_valid_d;
  logic             load_in;
  logic             advance;

  shm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  shm_eval u_eval (
    .cfg_i        (cfg),
    .state_i      (state_q),
    .bus_status_i (bus_status_q),
    .raw_bytes_i  (raw_bytes_q),
    .state_o      (state_d),
    .result_o     (result_d)
  );

  // Move the held word on when the result register is empty or being taken
  assign advance    = in_valid_q & (~out_valid_q | ~out_stall_i);
  // Stall input only when the held word cannot move on
  assign in_stall_o = in_valid_q & ~advance;
  assign load_in    = in_valid_i & ~in_stall_o;

  always_comb begin
    if (load_in) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  // Hold a stalled result, drop it once taken
  assign out_valid_d = advance | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      bus_status_q <= bus_status_i;
      raw_bytes_q  <= raw_bytes_i;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  // State changes only when a result loads, so it stands for that result
  assign out_valid_o       = out_valid_q;
  assign retry_request_o   = result_q.retry_request;
  assign publish_o         = result_q.publish;
  assign fault_bus_error_o = state_q.faults.bus_error;
  assign fault_nak_o       = state_q.faults.nak;
  assign fault_dropout_o   = state_q.faults.dropout;
  assign fault_range_o     = state_q.faults.range;
  assign fault_stuck_o     = state_q.faults.stuck;
  assign healthy_o         = (state_q.faults == '0);
  assign good_value_o      = state_q.last_accepted;
  assign value_valid_o     = state_q.have_accepted;

endmodule

`default_nettype wire

>>> rtl/shm_cfg_regs.sv
// ----------------------------------------------------------------------------
// shm_cfg_regs: configuration register file
// APB-style write and read of the six monitor settings.
// ----------------------------------------------------------------------------
`default_nettype none

module shm_cfg_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [shm_pkg::AddrW-1:0]  paddr,
  input  wire logic [shm_pkg::DataW-1:0]  pwdata,
  output logic      [shm_pkg::DataW-1:0]  prdata,
  output logic                            pready,
  output shm_pkg::shm_cfg_t               cfg_o
);
  import shm_pkg::*;

  // One byte per sample, everything else clear
  localparam shm_cfg_t CfgReset = '{
    bytes_per_sample:  BpsW'(1),
    nak_retry_limit:   '0,
    range_low:         '0,
    range_high:        '0,
    stuck_threshold:   '0,
    dropout_threshold: '0
  };

  shm_cfg_t   cfg_q, cfg_d;
  reg_index_e reg_idx;
  logic       wr_en;

  assign reg_idx = reg_index_e'(paddr[AddrW-1:2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_BYTES_PER_SAMPLE:  cfg_d.bytes_per_sample  = pwdata[BpsW-1:0];
        REG_NAK_RETRY_LIMIT:   cfg_d.nak_retry_limit   = pwdata[RetryW-1:0];
        REG_RANGE_LOW:         cfg_d.range_low         = $signed(pwdata);
        REG_RANGE_HIGH:        cfg_d.range_high        = $signed(pwdata);
        REG_STUCK_THRESHOLD:   cfg_d.stuck_threshold   = pwdata[CountW-1:0];
        REG_DROPOUT_THRESHOLD: cfg_d.dropout_threshold = pwdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BYTES_PER_SAMPLE:  prdata = DataW'(cfg_q.bytes_per_sample);
      REG_NAK_RETRY_LIMIT:   prdata = DataW'(cfg_q.nak_retry_limit);
      REG_RANGE_LOW:         prdata = cfg_q.range_low;
      REG_RANGE_HIGH:        prdata = cfg_q.range_high;
      REG_STUCK_THRESHOLD:   prdata = DataW'(cfg_q.stuck_threshold);
      REG_DROPOUT_THRESHOLD: prdata = DataW'(cfg_q.dropout_threshold);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/shm_eval.sv
// ----------------------------------------------------------------------------
// shm_eval: per-attempt evaluation
// Retry control, byte decode, range and stuck checks, dropout counting.
// ----------------------------------------------------------------------------
`default_nettype none

module shm_eval (
  input  wire shm_pkg::shm_cfg_t           cfg_i,
  input  wire shm_pkg::shm_state_t         state_i,
  input  wire logic [2:0]                  bus_status_i,
  input  wire logic [shm_pkg::DataW-1:0]   raw_bytes_i,
  output shm_pkg::shm_state_t              state_o,
  output shm_pkg::shm_result_t             result_o
);
  import shm_pkg::*;

  localparam int unsigned NbW = BpsW;

  bus_status_e             status;
  logic [RetryW:0]         tries;
  logic [NbW-1:0]          nbytes;
  logic [DataW-1:0]        value_u;
  logic signed [DataW-1:0] value;
  logic                    in_range;
  logic                    same_value;
  logic [CountW-1:0]       rep_next;
  logic [CountW-1:0]       nodata_next;

  assign status = bus_status_e'(bus_status_i);
  assign tries  = {1'b0, state_i.attempt_count} + (RetryW+1)'(1);

  // Clamp the byte count to 1..MAX_BYTES
  always_comb begin
    if (cfg_i.bytes_per_sample == '0) begin
      nbytes = NbW'(1);
    end else if (cfg_i.bytes_per_sample > NbW'(MAX_BYTES)) begin
      nbytes = NbW'(MAX_BYTES);
    end else begin
      nbytes = cfg_i.bytes_per_sample;
    end
  end

  // Keep only the low nbytes bytes
  always_comb begin
    for (int k = 0; k < DataW / 8; k++) begin
      value_u[8*k +: 8] = (NbW'(k) < nbytes) ? raw_bytes_i[8*k +: 8] : 8'h00;
    end
  end

  assign value      = $signed(value_u);
  assign in_range   = (value >= cfg_i.range_low) && (value <= cfg_i.range_high);
  assign same_value = state_i.have_accepted && (value == state_i.last_accepted);

  always_comb begin
    if (!same_value) begin
      rep_next = '0;
    end else if (state_i.repeat_count < cfg_i.stuck_threshold) begin
      rep_next = state_i.repeat_count + CountW'(1);
    end else begin
      rep_next = state_i.repeat_count;
    end
  end

  assign nodata_next = (state_i.nodata_count < cfg_i.dropout_threshold)
                     ? state_i.nodata_count + CountW'(1) : state_i.nodata_count;

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    state_o.attempt_count = '0;
    unique case (status)
      ST_NAK: begin
        if (tries <= {1'b0, cfg_i.nak_retry_limit}) begin
          state_o.attempt_count  = tries[RetryW-1:0];
          result_o.retry_request = 1'b1;
        end else begin
          state_o.faults.nak = 1'b1;
        end
      end
      ST_OK: begin
        state_o.faults.bus_error = 1'b0;
        state_o.faults.nak       = 1'b0;
        state_o.faults.dropout   = 1'b0;
        state_o.nodata_count     = '0;
        if (!in_range) begin
          state_o.faults.range = 1'b1;
        end else begin
          state_o.faults.range  = 1'b0;
          state_o.repeat_count  = rep_next;
          state_o.faults.stuck  = (rep_next >= cfg_i.stuck_threshold);
          state_o.last_accepted = value;
          state_o.have_accepted = 1'b1;
          result_o.publish      = 1'b1;
        end
      end
      ST_NO_DATA: begin
        state_o.nodata_count = nodata_next;
        if (nodata_next >= cfg_i.dropout_threshold) begin
          state_o.faults.dropout = 1'b1;
        end
      end
      default: begin
        state_o.faults.bus_error = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> verif/tb_sensor_health_monitor.sv
// ----------------------------------------------------------------------------
// tb_sensor_health_monitor: self-checking bench for the sensor health monitor
// Feeds bus read attempts through the valid/stall input channel in random
// bursts, stalls the result channel on its own pattern (with one long
// hold-off), and checks every result word field by field against a
// cycle-free predictor of the health state. Configuration goes through the
// APB-style port between phases, with read-back of every mapped register.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sensor_health_monitor;
  import shm_pkg::*;

  localparam int unsigned CLK_PERIOD    = 12;
  localparam int unsigned RESET_CYCLES  = 6;
  localparam int unsigned LONG_HOLD     = 400;    // receiver hold-off in cycles
  localparam int unsigned SETTLE_CYCLES = 4;      // idle time after the results drain
  localparam int unsigned RUN_LIMIT     = 600000; // cycles before giving up
  localparam int unsigned MAX_PRINTED   = 40;

  // Highest code the 3-bit status field can carry; 4 and up act as bus error
  localparam logic [2:0] STATUS_TOP   = 3'd7;
  // Word indexes past the register list; writes there must change nothing
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [2:0]       status;
    logic [DataW-1:0] raw;
  } attempt_t;

  typedef struct packed {
    logic             retry_request;
    logic             healthy;
    logic             bus_error;
    logic             nak;
    logic             dropout;
    logic             out_of_range;
    logic             stuck;
    logic [DataW-1:0] good_value;
    logic             value_valid;
    logic             publish;
  } health_word_t;

  typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;

  // --------------------------------------------------------------------------
  // Block ports
  // --------------------------------------------------------------------------
  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    psel         = 1'b0;
  logic                    penable      = 1'b0;
  logic                    pwrite       = 1'b0;
  logic [AddrW-1:0]        paddr        = '0;
  logic [DataW-1:0]        pwdata       = '0;
  logic [DataW-1:0]        prdata;
  logic                    pready;
  logic                    in_valid_i   = 1'b0;
  logic                    in_stall_o;
  logic [2:0]              bus_status_i = '0;
  logic [DataW-1:0]        raw_bytes_i  = '0;
  logic                    out_valid_o;
  logic                    out_stall_i  = 1'b0;
  logic                    retry_request_o;
  logic                    healthy_o;
  logic                    fault_bus_error_o;
  logic                    fault_nak_o;
  logic                    fault_dropout_o;
  logic                    fault_range_o;
  logic                    fault_stuck_o;
  logic signed [DataW-1:0] good_value_o;
  logic                    value_valid_o;
  logic                    publish_o;

  sensor_health_monitor uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .bus_status_i      (bus_status_i),
    .raw_bytes_i       (raw_bytes_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .retry_request_o   (retry_request_o),
    .healthy_o         (healthy_o),
    .fault_bus_error_o (fault_bus_error_o),
    .fault_nak_o       (fault_nak_o),
    .fault_dropout_o   (fault_dropout_o),
    .fault_range_o     (fault_range_o),
    .fault_stuck_o     (fault_stuck_o),
    .good_value_o      (good_value_o),
    .value_valid_o     (value_valid_o),
    .publish_o         (publish_o)
  );

  // --------------------------------------------------------------------------
  // Clock and run limit
  // --------------------------------------------------------------------------
  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #(CLK_PERIOD * RUN_LIMIT);
    $display("** sensor_health_monitor: FAILED **");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  attempt_t     attempt_queue[$];    // attempts waiting for the driver
  health_word_t expected_reports[$]; // predicted result words, oldest first
  int unsigned  mismatches = 0;
  logic         word_taken = 1'b0;   // input word accepted at the last rising edge
  int unsigned  hold_requests = 0;   // bumped to ask the receiver for a long hold
  logic [DataW-1:0] recent_sample = '0;

  // Health predictor: its own copy of the configuration and the state
  shm_cfg_t                cfg_shadow;
  shm_faults_t             faults;
  logic signed [DataW-1:0] last_sample;
  logic                    have_sample;
  logic [CountW-1:0]       nodata_run;
  logic [CountW-1:0]       repeat_run;
  logic [RetryW-1:0]       poll_naks;

  task automatic log_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [DataW-1:0] got,
                             input logic [DataW-1:0] want);
    if (got !== want) log_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Bytes kept from raw_bytes; a count of 0 acts as 1, above MAX_BYTES as MAX_BYTES
  function automatic logic [DataW-1:0] sample_mask();
    int unsigned n;
    n = cfg_shadow.bytes_per_sample;
    if (n == 0) n = 1;
    if (n > MAX_BYTES) n = MAX_BYTES;
    if (n >= 4) return '1;
    return (32'h1 << (8 * n)) - 32'h1;
  endfunction

  // Advance the health state by one attempt and return the result word it gives
  function automatic health_word_t predict_health(input logic [2:0] status,
                                                  input logic [DataW-1:0] raw);
    health_word_t            w;
    logic [RetryW:0]         tries;
    logic signed [DataW-1:0] v;
    logic                    retry;
    logic                    pub;
    retry = 1'b0;
    pub   = 1'b0;
    if (status == ST_NAK) begin
      // count NAKs within one poll; the budget is one attempt plus the retries
      tries = {1'b0, poll_naks} + 1'b1;
      if (tries <= {1'b0, cfg_shadow.nak_retry_limit}) begin
        poll_naks = tries[RetryW-1:0];
        retry     = 1'b1;
      end else begin
        poll_naks  = '0;
        faults.nak = 1'b1;
      end
    end else begin
      poll_naks = '0;
      if (status == ST_OK) begin
        v = raw & sample_mask();
        faults.bus_error = 1'b0;
        faults.nak       = 1'b0;
        faults.dropout   = 1'b0;
        nodata_run       = '0;
        if (v < $signed(cfg_shadow.range_low) || v > $signed(cfg_shadow.range_high)) begin
          faults.range = 1'b1;
        end else begin
          faults.range = 1'b0;
          if (have_sample && v == last_sample) begin
            if (repeat_run < cfg_shadow.stuck_threshold) repeat_run++;
          end else begin
            repeat_run = '0;
          end
          faults.stuck = (repeat_run >= cfg_shadow.stuck_threshold);
          last_sample  = v;
          have_sample  = 1'b1;
          pub          = 1'b1;
        end
      end else if (status == ST_NO_DATA) begin
        if (nodata_run < cfg_shadow.dropout_threshold) nodata_run++;
        if (nodata_run >= cfg_shadow.dropout_threshold) faults.dropout = 1'b1;
      end else begin
        // bus error and every unknown code
        faults.bus_error = 1'b1;
      end
    end
    w.retry_request = retry;
    w.healthy       = (faults == '0);
    w.bus_error     = faults.bus_error;
    w.nak           = faults.nak;
    w.dropout       = faults.dropout;
    w.out_of_range  = faults.range;
    w.stuck         = faults.stuck;
    w.good_value    = last_sample;
    w.value_valid   = have_sample;
    w.publish       = pub;
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    health_word_t want;
    word_taken = 1'b0;
    if (rst_ni) begin
      // predict on acceptance so expectations stay in input order
      if (in_valid_i && !in_stall_o) begin
        expected_reports.push_back(predict_health(bus_status_i, raw_bytes_i));
        word_taken = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_reports.size() == 0) begin
          log_mismatch("result word with no attempt pending");
        end else begin
          want = expected_reports.pop_front();
          check_field("retry_request", retry_request_o, want.retry_request);
          check_field("healthy", healthy_o, want.healthy);
          check_field("fault_bus_error", fault_bus_error_o, want.bus_error);
          check_field("fault_nak", fault_nak_o, want.nak);
          check_field("fault_dropout", fault_dropout_o, want.dropout);
          check_field("fault_range", fault_range_o, want.out_of_range);
          check_field("fault_stuck", fault_stuck_o, want.stuck);
          check_field("good_value", good_value_o, want.good_value);
          check_field("value_valid", value_valid_o, want.value_valid);
          check_field("publish", publish_o, want.publish);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver: bursts of attempts with random gaps, changes at the falling edge
  // --------------------------------------------------------------------------
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin
    attempt_t head;
    // hold a stalled word; otherwise the slot is free for the next one
    if (!in_valid_i || word_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (attempt_queue.size() != 0) begin
        head = attempt_queue.pop_front();
        in_valid_i   <= 1'b1;
        bus_status_i <= head.status;
        raw_bytes_i  <= head.raw;
        if (burst_left <= 1) begin
          // draw the next burst; zero gaps give back-to-back stretches
          burst_left = $urandom_range(1, 48);
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 9: gap_left = 0;
            4, 5, 6, 7:    gap_left = $urandom_range(1, 4);
            default:       gap_left = $urandom_range(5, 16);
          endcase
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall on a pattern that changes mode every so often, plus a
  // long hold-off on request that backs the block up into its input
  // --------------------------------------------------------------------------
  rx_mode_e    stall_mode = RX_FREE;
  int unsigned mode_left  = 0;
  int unsigned hold_left  = 0;
  int unsigned hold_seen  = 0;
  logic [7:0]  stall_tick = '0;

  always @(negedge clk_i) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = rx_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(16, 160);
      end else begin
        mode_left--;
      end
      stall_tick++;
      case (stall_mode)
        RX_FREE:  out_stall_i <= 1'b0;
        RX_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall_i <= ($urandom_range(0, 9) < 7);
        default:  out_stall_i <= (stall_tick[2:0] < 3'd3);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Configuration port access: setup cycle, then access until pready
  // --------------------------------------------------------------------------
  task automatic apb_access(input logic wr, input logic [2:0] idx,
                            input logic [DataW-1:0] wdata, output logic [DataW-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write one register, mirror it in the predictor and read it back
  task automatic set_reg(input logic [2:0] idx, input logic [DataW-1:0] value);
    logic [DataW-1:0] readback;
    logic [DataW-1:0] want;
    logic             mapped;
    mapped = 1'b1;
    want   = '0;
    apb_access(1'b1, idx, value, readback);
    case (idx)
      REG_BYTES_PER_SAMPLE: begin
        cfg_shadow.bytes_per_sample = value[BpsW-1:0];
        want = DataW'(value[BpsW-1:0]);
      end
      REG_NAK_RETRY_LIMIT: begin
        cfg_shadow.nak_retry_limit = value[RetryW-1:0];
        want = DataW'(value[RetryW-1:0]);
      end
      REG_RANGE_LOW: begin
        cfg_shadow.range_low = value;
        want = value;
      end
      REG_RANGE_HIGH: begin
        cfg_shadow.range_high = value;
        want = value;
      end
      REG_STUCK_THRESHOLD: begin
        cfg_shadow.stuck_threshold = value[CountW-1:0];
        want = DataW'(value[CountW-1:0]);
      end
      REG_DROPOUT_THRESHOLD: begin
        cfg_shadow.dropout_threshold = value[CountW-1:0];
        want = DataW'(value[CountW-1:0]);
      end
      default: mapped = 1'b0;
    endcase
    if (mapped) begin
      apb_access(1'b0, idx, '0, readback);
      check_field($sformatf("register %0d read-back", idx), readback, want);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_attempt(input logic [2:0] status, input logic [DataW-1:0] raw);
    attempt_t a;
    a.status = status;
    a.raw    = raw;
    attempt_queue.push_back(a);
  endtask

  // Good read of a sample; bytes above the sample width get random junk
  task automatic add_good(input logic [DataW-1:0] v);
    logic [DataW-1:0] mask;
    mask = sample_mask();
    recent_sample = v;
    add_attempt(ST_OK, (DataW'($urandom) & ~mask) | (v & mask));
  endtask

  // Sample values: range bounds, their neighbors, repeats, in-range and random values
  function automatic logic [DataW-1:0] pick_sample();
    logic [DataW-1:0] lo;
    logic [DataW-1:0] hi;
    logic [DataW-1:0] span;
    logic [DataW-1:0] off;
    lo = cfg_shadow.range_low;
    hi = cfg_shadow.range_high;
    case ($urandom_range(0, 7))
      0: return lo;
      1: return hi;
      2: return lo - 1'b1;
      3: return hi + 1'b1;
      4: return recent_sample;
      5, 6: begin
        if ($signed(lo) > $signed(hi)) return $urandom;
        span = hi - lo;
        off  = $urandom;
        if (span != '1) off = off % (span + 1'b1);
        return lo + off;
      end
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed polls with random content, the rest broken or noise
  task automatic queue_polls(input int unsigned target);
    int unsigned      added;
    int unsigned      pick;
    int unsigned      run;
    int unsigned      limit;
    int unsigned      stuck_thr;
    int unsigned      drop_thr;
    logic [DataW-1:0] v;
    added     = 0;
    limit     = cfg_shadow.nak_retry_limit;
    stuck_thr = cfg_shadow.stuck_threshold;
    drop_thr  = cfg_shadow.dropout_threshold;
    while (added < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // good read, sometimes after NAKs that stay inside the retry budget
        run = 0;
        if (limit != 0 && $urandom_range(0, 2) == 0)
          run = $urandom_range(1, (limit > 6) ? 6 : limit);
        repeat (run) add_attempt(ST_NAK, $urandom);
        add_good(pick_sample());
        added += run + 1;
      end else if (pick < 52) begin
        // one value over and over to walk the repeat counter
        v   = pick_sample();
        run = $urandom_range(2, (stuck_thr > 9) ? 12 : stuck_thr + 3);
        repeat (run) add_good(v);
        added += run;
      end else if (pick < 64) begin
        // exhaust a small retry budget, else a random run that may stop short of it
        if (limit <= 12 && $urandom_range(0, 1) == 1) run = limit + 1;
        else run = $urandom_range(1, (limit > 11) ? 12 : limit + 1);
        repeat (run) add_attempt(ST_NAK, $urandom);
        added += run;
      end else if (pick < 76) begin
        run = $urandom_range(1, (drop_thr > 10) ? 12 : drop_thr + 2);
        repeat (run) add_attempt(ST_NO_DATA, $urandom);
        added += run;
      end else if (pick < 84) begin
        if ($urandom_range(0, 1) == 1) add_attempt(ST_BUS_ERR, $urandom);
        else add_attempt(3'($urandom_range(ST_UNKNOWN, STATUS_TOP)), $urandom);
        added++;
      end else begin
        add_attempt(3'($urandom_range(0, STATUS_TOP)), $urandom);
        added++;
      end
    end
  endtask

  // Wait until every queued word is in and every result is out, then let
  // the pipeline go quiet before touching the registers
  task automatic settle();
    do @(posedge clk_i);
    while (attempt_queue.size() != 0 || in_valid_i || expected_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned k;
    // predictor starts from the reset values of the block
    cfg_shadow                  = '0;
    cfg_shadow.bytes_per_sample = 3'd1;
    faults      = '0;
    last_sample = '0;
    have_sample = 1'b0;
    nodata_run  = '0;
    repeat_run  = '0;
    poll_naks   = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // Reset settings: one byte, no retries, range 0..0, zero thresholds.
    // Drop upper bytes, hit each status and clear bus, NAK, dropout and range faults.
    add_attempt(ST_OK, 32'h0000_0000);
    add_attempt(ST_OK, 32'hFFFF_FF00);
    add_attempt(ST_OK, 32'h0000_00FF);
    add_attempt(ST_NAK, 32'h0000_0000);
    add_attempt(ST_BUS_ERR, 32'hFFFF_FFFF);
    add_attempt(ST_NO_DATA, 32'h0000_0000);
    add_attempt(ST_UNKNOWN, 32'h0000_0000);
    add_attempt(STATUS_TOP, 32'hFFFF_FFFF);
    add_attempt(ST_OK, 32'h1234_5600);
    queue_polls(150);
    settle();

    // Two bytes, three retries, positive range, small thresholds
    set_reg(REG_BYTES_PER_SAMPLE, 32'd2);
    set_reg(REG_NAK_RETRY_LIMIT, 32'd3);
    set_reg(REG_RANGE_LOW, 32'd0);
    set_reg(REG_RANGE_HIGH, 32'd40000);
    set_reg(REG_STUCK_THRESHOLD, 32'd2);
    set_reg(REG_DROPOUT_THRESHOLD, 32'd3);
    repeat (4) add_attempt(ST_NAK, $urandom);   // last one ends the poll
    add_attempt(ST_NAK, $urandom);              // retry in progress keeps the state
    add_attempt(ST_OK, 32'hABCD_1234);
    add_attempt(ST_OK, 32'h5555_1234);
    add_attempt(ST_OK, 32'h0000_1234);          // stuck after two repeats
    repeat (3) add_attempt(ST_NO_DATA, $urandom);
    add_attempt(ST_OK, 32'h0000_FFFF);          // above the range
    add_attempt(3'(ST_UNKNOWN) + 3'd1, $urandom);
    add_attempt(STATUS_TOP - 3'd1, $urandom);
    queue_polls(300);
    // keep offering words while the receiver holds off for a long stretch
    hold_requests++;
    settle();

    // Widest sample, full signed range, largest retry limit, zero thresholds
    set_reg(REG_BYTES_PER_SAMPLE, 32'd4);
    set_reg(REG_NAK_RETRY_LIMIT, 32'd255);
    set_reg(REG_RANGE_LOW, 32'h8000_0000);
    set_reg(REG_RANGE_HIGH, 32'h7FFF_FFFF);
    set_reg(REG_STUCK_THRESHOLD, 32'd0);
    set_reg(REG_DROPOUT_THRESHOLD, 32'd0);
    for (k = 0; k < 256; k++) add_attempt(ST_NAK, $urandom);
    add_attempt(ST_NAK, $urandom);              // starts a fresh poll
    add_attempt(ST_OK, 32'h8000_0000);
    add_attempt(ST_OK, 32'h7FFF_FFFF);
    add_attempt(ST_NO_DATA, $urandom);
    queue_polls(240);
    settle();

    // Byte count zero (junk above the field), empty range, largest thresholds,
    // and writes past the register list that must leave everything alone
    set_reg(REG_SPARE_LO, $urandom);
    set_reg(REG_SPARE_HI, $urandom);
    set_reg(REG_BYTES_PER_SAMPLE, 32'hFFFF_FFF8);
    set_reg(REG_NAK_RETRY_LIMIT, 32'd1);
    set_reg(REG_RANGE_LOW, 32'd1);
    set_reg(REG_RANGE_HIGH, 32'hFFFF_FFFF);
    set_reg(REG_STUCK_THRESHOLD, 32'hFFFF);
    set_reg(REG_DROPOUT_THRESHOLD, 32'hFFFF);
    queue_polls(300);
    settle();

    // Byte count above the maximum, narrow signed range around zero
    set_reg(REG_BYTES_PER_SAMPLE, 32'd7);
    set_reg(REG_NAK_RETRY_LIMIT, 32'd2);
    set_reg(REG_RANGE_LOW, 32'hFFFF_FF9C);
    set_reg(REG_RANGE_HIGH, 32'd100);
    set_reg(REG_STUCK_THRESHOLD, 32'd1);
    set_reg(REG_DROPOUT_THRESHOLD, 32'd1);
    queue_polls(300);
    settle();

    // A few random settings
    repeat (3) begin
      set_reg(REG_BYTES_PER_SAMPLE, $urandom_range(0, 7));
      set_reg(REG_NAK_RETRY_LIMIT,
              ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 5));
      set_reg(REG_RANGE_LOW, $urandom);
      set_reg(REG_RANGE_HIGH, $urandom);
      // keep the range non-empty most of the time
      if ($signed(cfg_shadow.range_low) > $signed(cfg_shadow.range_high) &&
          $urandom_range(0, 3) != 0) begin
        set_reg(REG_RANGE_LOW, cfg_shadow.range_high);
        set_reg(REG_RANGE_HIGH, $urandom);
        if ($signed(cfg_shadow.range_low) > $signed(cfg_shadow.range_high))
          set_reg(REG_RANGE_HIGH, 32'h7FFF_FFFF);
      end
      set_reg(REG_STUCK_THRESHOLD, $urandom_range(0, 8));
      set_reg(REG_DROPOUT_THRESHOLD, $urandom_range(0, 8));
      queue_polls(150);
      settle();
    end

    repeat (8) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("** sensor_health_monitor: PASSED **");
    end else begin
      $display("** sensor_health_monitor: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
rtl/shm_pkg.sv
rtl/shm_cfg_regs.sv
rtl/shm_eval.sv
rtl/sensor_health_monitor.sv
verif/tb_sensor_health_monitor.sv
